/* rtl/cseu_pkg.sv */
// Package for the execute unit core: word kinds, ALU codes and sizes.
// No dependencies.
`timescale 1ns / 1ps

package cseu_pkg;

    localparam int unsigned MemAddrBitsDefault = 16;

    typedef enum logic [1:0] {
        t_KIND_EXEC  = 2'd0,
        t_KIND_WRITE = 2'd1,
        t_KIND_READ  = 2'd2,
        t_KIND_NONE  = 2'd3
    } t_kind;

    localparam logic [2:0] AluAdd = 3'd0;
    localparam logic [2:0] AluAdc = 3'd1;
    localparam logic [2:0] AluSub = 3'd2;
    localparam logic [2:0] AluSbc = 3'd3;
    localparam logic [2:0] AluAnd = 3'd4;
    localparam logic [2:0] AluXor = 3'd5;
    localparam logic [2:0] AluOr  = 3'd6;
    localparam logic [2:0] AluCp  = 3'd7;

    localparam logic [2:0] OperandMem = 3'd6;
    localparam logic [2:0] OperandA   = 3'd7;

    typedef struct packed {
        logic [7:0] res;
        logic [7:0] flags;
        logic       wr_a;
    } t_alu_out;

    function automatic t_alu_out alu_op(input logic [2:0] op, input logic [7:0] a,
                                         input logic [7:0] v, input logic [7:0] f);
        t_alu_out o;
        logic [8:0] s;
        logic [4:0] h;
        logic       cin;
        cin = f[4];
        o.wr_a = 1'b1;
        o.res = 8'd0;
        o.flags = 8'd0;
        unique case (op)
            AluAdd, AluAdc: begin
                if (op == AluAdd) cin = 1'b0;
                s = {1'b0, a} + {1'b0, v} + {8'd0, cin};
                h = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
                o.res = s[7:0];
                o.flags = {s[7:0] == 8'd0, 1'b0, h[4], s[8], 4'd0};
            end
            AluSub, AluSbc, AluCp: begin
                if (op != AluSbc) cin = 1'b0;
                s = {1'b0, a} - {1'b0, v} - {8'd0, cin};
                h = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cin};
                o.res = s[7:0];
                o.flags = {s[7:0] == 8'd0, 1'b1, h[4], s[8], 4'd0};
                o.wr_a = (op != AluCp);
            end
            AluAnd: begin
                o.res = a & v;
                o.flags = {(a & v) == 8'd0, 1'b0, 1'b1, 1'b0, 4'd0};
            end
            AluXor: begin
                o.res = a ^ v;
                o.flags = {(a ^ v) == 8'd0, 3'b000, 4'd0};
            end
            default: begin
                o.res = a | v;
                o.flags = {(a | v) == 8'd0, 3'b000, 4'd0};
            end
        endcase
        return o;
    endfunction

endpackage

/* rtl/cseu_ram.sv */
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module cseu_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* rtl/cpu_subset_execute_unit_core.sv */
// Execute unit for a subset of an 8-bit CPU instruction set, with its byte memory.
// Depends on cseu_pkg and cseu_ram.
`timescale 1ns / 1ps

// Each accepted word carries one opcode to execute, or one memory byte write or
// read. Each word yields one result word that holds the whole register file after
// the step. The byte memory is a single-port RAM with a registered read, and
// every access goes through that one port. S_EXEC issues the first memory access.
// The next step (S_RD1, S_WR2 or S_DONE) finishes the step: read data arrives,
// INC and DEC of (HL) write the new byte back, and PUSH and LD (a16),SP write their
// second byte. POP reads two bytes, so it passes through S_RD1 and S_RD2 before
// its result is valid. Once the result word is taken, the unit goes back to idle.
// After reset the unit sweeps the memory to zero, one byte a cycle. It takes no
// word before the sweep is done. A result waits in the output registers, and the
// input is held off until that result has been taken.
// Unimplemented opcodes leave the state as it is. They report executed low, with
// zero length and zero cycle count.
module cpu_subset_execute_unit_core
    import cseu_pkg::*;
#(
    parameter int unsigned MEM_ADDR_BITS = MemAddrBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_opcode,
    input  logic [15:0] i_imm_word,
    input  logic [15:0] i_mem_addr,
    input  logic [7:0]  i_mem_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_reg_a,
    output logic [7:0]  o_reg_flags,
    output logic [15:0] o_pair_bc,
    output logic [15:0] o_pair_de,
    output logic [15:0] o_pair_hl,
    output logic [15:0] o_stack_ptr,
    output logic [1:0]  o_instr_length,
    output logic [4:0]  o_instr_cycles,
    output logic        o_executed,
    output logic [7:0]  o_read_byte
);
    localparam int unsigned AW = MEM_ADDR_BITS;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_RD1, S_RD2, S_WR2, S_DONE
    } t_state;

    t_state r_state;
    logic [AW:0]    r_clr;
    logic [7:0]     r_op;
    logic [15:0]    r_imm;
    logic [15:0]    r_addr;
    logic [7:0]     r_data;
    logic [1:0]     r_kind;
    logic [7:0]     r_a, r_f;
    logic [15:0]    r_bc, r_de, r_hl, r_sp;
    logic [7:0]     r_lo;

    // Memory port signals, driven combinationally by the sequencer.
    logic          m_we;
    logic [AW-1:0] m_addr;
    logic [7:0]    m_wdata, m_rdata;

    cseu_ram #(.Width(8), .Depth(1 << AW)) u_ram (
        .i_clk(i_clk), .i_we(m_we), .i_addr(m_addr), .i_wdata(m_wdata), .o_rdata(m_rdata)
    );

    // Opcode decode.
    logic [2:0] dx, dz;
    logic [1:0] pi;
    assign dx = r_op[5:3];
    assign dz = r_op[2:0];
    assign pi = r_op[5:4];

    logic is_ld88, is_alu, is_alui, is_push, is_pop, is_ldsp;
    logic is_ld16, is_incdec16, is_ldind, is_incdec8, is_ldi8;
    always_comb begin
        is_ldsp     = (r_op == 8'h08);
        is_ld88     = (r_op[7:6] == 2'b01) && (r_op != 8'h76);
        is_alu      = (r_op[7:6] == 2'b10);
        is_alui     = (r_op[7:6] == 2'b11) && (dz == 3'd6);
        is_push     = (r_op[7:6] == 2'b11) && (r_op[3:0] == 4'h5);
        is_pop      = (r_op[7:6] == 2'b11) && (r_op[3:0] == 4'h1);
        is_ld16     = (r_op[7:6] == 2'b00) && (r_op[3:0] == 4'h1);
        is_incdec16 = (r_op[7:6] == 2'b00) && (r_op[2:0] == 3'd3);
        is_ldind    = (r_op[7:6] == 2'b00) && (r_op[2:0] == 3'd2);
        is_incdec8  = (r_op[7:6] == 2'b00) && (dz == 3'd4 || dz == 3'd5);
        is_ldi8     = (r_op[7:6] == 2'b00) && (dz == 3'd6);
    end

    logic [15:0] ind_addr;
    always_comb begin
        unique case (pi)
            2'd0:    ind_addr = r_bc;
            2'd1:    ind_addr = r_de;
            default: ind_addr = r_hl;
        endcase
    end

    function automatic logic [7:0] get_r(input logic [2:0] i, input logic [7:0] a,
                                         input logic [15:0] bc, input logic [15:0] de,
                                         input logic [15:0] hl, input logic [7:0] m);
        logic [7:0] v;
        unique case (i)
            3'd0: v = bc[15:8];
            3'd1: v = bc[7:0];
            3'd2: v = de[15:8];
            3'd3: v = de[7:0];
            3'd4: v = hl[15:8];
            3'd5: v = hl[7:0];
            3'd6: v = m;
            default: v = a;
        endcase
        return v;
    endfunction

    // Whether this opcode reads a memory byte before completing.
    logic needs_rd;
    always_comb begin
        needs_rd = (is_ld88 && dz == OperandMem) || (is_alu && dz == OperandMem)
                || is_pop || (is_ldind && r_op[3]) || (is_incdec8 && dx == OperandMem);
    end

    // Register values presented at finish; m_rdata is the byte read in this cycle.
    logic [7:0]  n_a, n_f, src, idr;
    logic [15:0] n_bc, n_de, n_hl, n_sp, p16;
    logic [1:0]  n_len;
    logic [4:0]  n_cyc;
    logic        n_exec;
    t_alu_out    ao;

    always_comb begin
        n_a = r_a; n_f = r_f; n_bc = r_bc; n_de = r_de; n_hl = r_hl; n_sp = r_sp;
        n_len = 2'd1; n_cyc = 5'd4; n_exec = 1'b1;
        m_we = 1'b0; m_addr = r_addr[AW-1:0]; m_wdata = r_data;
        src = get_r(dz, r_a, r_bc, r_de, r_hl, m_rdata);
        idr = get_r(dx, r_a, r_bc, r_de, r_hl, m_rdata);
        ao  = alu_op(dx, r_a, is_alui ? r_imm[7:0] : src, r_f);
        unique case (pi)
            2'd0: p16 = r_bc;
            2'd1: p16 = r_de;
            2'd2: p16 = r_hl;
            default: p16 = r_sp;
        endcase
        if (r_kind != t_KIND_EXEC) begin
            n_len = 2'd0; n_cyc = 5'd0; n_exec = 1'b0;
        end else if (r_op == 8'h00) begin
        end else if (is_ldsp) begin
            n_len = 2'd3; n_cyc = 5'd20;
        end else if (is_ld88) begin
            if (dx == OperandMem || dz == OperandMem) n_cyc = 5'd8;
            unique case (dx)
                3'd0: n_bc[15:8] = src;
                3'd1: n_bc[7:0] = src;
                3'd2: n_de[15:8] = src;
                3'd3: n_de[7:0] = src;
                3'd4: n_hl[15:8] = src;
                3'd5: n_hl[7:0] = src;
                3'd6: ;
                default: n_a = src;
            endcase
        end else if (is_alu || is_alui) begin
            if (ao.wr_a) n_a = ao.res;
            n_f = ao.flags;
            if (is_alui) begin n_len = 2'd2; n_cyc = 5'd8; end
            else if (dz == OperandMem) n_cyc = 5'd8;
        end else if (is_push) begin
            n_cyc = 5'd16;
            n_sp = r_sp - 16'd2;
        end else if (is_pop) begin
            n_cyc = 5'd12;
            n_sp = r_sp + 16'd2;
            unique case (pi)
                2'd0: n_bc = {m_rdata, r_lo};
                2'd1: n_de = {m_rdata, r_lo};
                2'd2: n_hl = {m_rdata, r_lo};
                default: begin n_a = m_rdata; n_f = {r_lo[7:4], 4'd0}; end
            endcase
        end else if (is_ld16) begin
            n_len = 2'd3; n_cyc = 5'd12;
            unique case (pi)
                2'd0: n_bc = r_imm;
                2'd1: n_de = r_imm;
                2'd2: n_hl = r_imm;
                default: n_sp = r_imm;
            endcase
        end else if (is_incdec16) begin
            n_cyc = 5'd8;
            unique case (pi)
                2'd0: n_bc = r_op[3] ? r_bc - 16'd1 : r_bc + 16'd1;
                2'd1: n_de = r_op[3] ? r_de - 16'd1 : r_de + 16'd1;
                2'd2: n_hl = r_op[3] ? r_hl - 16'd1 : r_hl + 16'd1;
                default: n_sp = r_op[3] ? r_sp - 16'd1 : r_sp + 16'd1;
            endcase
        end else if (is_ldind) begin
            n_cyc = 5'd8;
            if (r_op[3]) n_a = m_rdata;
            if (pi == 2'd2) n_hl = r_hl + 16'd1;
            if (pi == 2'd3) n_hl = r_hl - 16'd1;
        end else if (is_incdec8) begin
            logic [7:0] rr;
            rr = (dz == 3'd4) ? idr + 8'd1 : idr - 8'd1;
            n_f = {rr == 8'd0, dz == 3'd5,
                   (dz == 3'd4) ? (idr[3:0] == 4'hF) : (idr[3:0] == 4'h0), r_f[4], 4'd0};
            n_cyc = (dx == OperandMem) ? 5'd12 : 5'd4;
            unique case (dx)
                3'd0: n_bc[15:8] = rr;
                3'd1: n_bc[7:0] = rr;
                3'd2: n_de[15:8] = rr;
                3'd3: n_de[7:0] = rr;
                3'd4: n_hl[15:8] = rr;
                3'd5: n_hl[7:0] = rr;
                3'd6: ;
                default: n_a = rr;
            endcase
            if (dx == OperandMem) m_wdata = rr;
        end else if (is_ldi8) begin
            n_len = 2'd2;
            n_cyc = (dx == OperandMem) ? 5'd12 : 5'd8;
            unique case (dx)
                3'd0: n_bc[15:8] = r_imm[7:0];
                3'd1: n_bc[7:0] = r_imm[7:0];
                3'd2: n_de[15:8] = r_imm[7:0];
                3'd3: n_de[7:0] = r_imm[7:0];
                3'd4: n_hl[15:8] = r_imm[7:0];
                3'd5: n_hl[7:0] = r_imm[7:0];
                3'd6: ;
                default: n_a = r_imm[7:0];
            endcase
        end else begin
            n_len = 2'd0; n_cyc = 5'd0; n_exec = 1'b0;
            n_a = r_a; n_f = r_f;
        end

        // Memory port control per sequencer step.
        unique case (r_state)
            S_CLEAR: begin
                m_we = 1'b1; m_addr = r_clr[AW-1:0]; m_wdata = 8'd0;
            end
            S_EXEC: begin
                // First access of the word, or the only one.
                if (r_kind == t_KIND_WRITE) begin
                    m_we = 1'b1;
                end else if (r_kind != t_KIND_EXEC) begin
                    m_we = 1'b0;
                end else if (is_ldsp) begin
                    m_we = 1'b1; m_addr = r_imm[AW-1:0]; m_wdata = r_sp[7:0];
                end else if (is_push) begin
                    m_we = 1'b1; m_addr = n_sp[AW-1:0];
                    m_wdata = (pi == 2'd3) ? r_f : p16[7:0];
                end else if (is_pop) begin
                    m_addr = r_sp[AW-1:0];
                end else if (is_ldind) begin
                    m_addr = ind_addr[AW-1:0];
                    m_we = !r_op[3]; m_wdata = r_a;
                end else if (is_ld88 && dx == OperandMem) begin
                    m_addr = r_hl[AW-1:0];
                    m_we = (dz != OperandMem); m_wdata = src;
                end else if (is_ldi8 && dx == OperandMem) begin
                    m_addr = r_hl[AW-1:0]; m_we = 1'b1; m_wdata = r_imm[7:0];
                end else begin
                    m_addr = r_hl[AW-1:0];
                end
            end
            S_RD1: begin
                m_addr = r_addr[AW-1:0];
                if (r_kind == t_KIND_EXEC && is_ld88 && dx == OperandMem) begin
                    m_we = 1'b1; m_wdata = m_rdata;
                end else if (r_kind == t_KIND_EXEC && is_incdec8 && dx == OperandMem) begin
                    m_we = 1'b1;
                end
            end
            S_WR2: begin
                m_we = 1'b1; m_addr = r_addr[AW-1:0];
                m_wdata = is_ldsp ? r_sp[15:8] : ((pi == 2'd3) ? r_a : p16[15:8]);
            end
            S_RD2: m_addr = r_addr[AW-1:0];
            default: ;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            o_valid <= 1'b0;
            r_a <= 8'd0; r_f <= 8'd0;
            r_bc <= 16'd0; r_de <= 16'd0; r_hl <= 16'd0; r_sp <= 16'd0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW + 1)'((1 << AW) - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind <= i_kind; r_op <= i_opcode; r_imm <= i_imm_word;
                        r_addr <= i_mem_addr; r_data <= i_mem_data;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_addr <= 16'(m_addr) + ((is_ldsp || is_push || is_pop)
                              ? 16'd1 : 16'd0);
                    if (r_kind == t_KIND_READ) r_state <= S_RD1;
                    else if (r_kind == t_KIND_EXEC && (is_ldsp || is_push)) r_state <= S_WR2;
                    else if (r_kind == t_KIND_EXEC && needs_rd) r_state <= S_RD1;
                    else r_state <= S_DONE;
                end
                S_RD1: begin
                    if (r_kind == t_KIND_EXEC && is_pop) begin
                        r_lo <= m_rdata;
                        r_state <= S_RD2;
                    end else begin
                        r_lo <= m_rdata;
                        o_read_byte <= (r_kind == t_KIND_READ) ? m_rdata : 8'd0;
                        o_reg_a <= n_a; o_reg_flags <= n_f;
                        o_pair_bc <= n_bc; o_pair_de <= n_de; o_pair_hl <= n_hl;
                        o_stack_ptr <= n_sp; o_instr_length <= n_len;
                        o_instr_cycles <= n_cyc; o_executed <= n_exec;
                        r_a <= n_a; r_f <= n_f; r_bc <= n_bc; r_de <= n_de;
                        r_hl <= n_hl; r_sp <= n_sp;
                        o_valid <= 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_RD2, S_WR2: begin
                    o_read_byte <= 8'd0;
                    o_reg_a <= n_a; o_reg_flags <= n_f;
                    o_pair_bc <= n_bc; o_pair_de <= n_de; o_pair_hl <= n_hl;
                    o_stack_ptr <= n_sp; o_instr_length <= n_len;
                    o_instr_cycles <= n_cyc; o_executed <= n_exec;
                    r_a <= n_a; r_f <= n_f; r_bc <= n_bc; r_de <= n_de;
                    r_hl <= n_hl; r_sp <= n_sp;
                    o_valid <= 1'b1;
                    r_state <= S_DONE;
                end
                default: begin
                    // S_DONE: publish on entry from S_EXEC, then wait for the taker.
                    if (!o_valid) begin
                        o_read_byte <= 8'd0;
                        o_reg_a <= n_a; o_reg_flags <= n_f;
                        o_pair_bc <= n_bc; o_pair_de <= n_de; o_pair_hl <= n_hl;
                        o_stack_ptr <= n_sp; o_instr_length <= n_len;
                        o_instr_cycles <= n_cyc; o_executed <= n_exec;
                        r_a <= n_a; r_f <= n_f; r_bc <= n_bc; r_de <= n_de;
                        r_hl <= n_hl; r_sp <= n_sp;
                        o_valid <= 1'b1;
                    end else if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // The input is never taken while a result is pending.
    a_no_accept_while_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input accepted with result pending");
    // An accepted word always leaves idle next cycle.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready) else $error("accept did not start work");
    // Not-executed results carry zero length and cycles.
    a_not_exec_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_executed) |-> (o_instr_length == 2'd0 && o_instr_cycles == 5'd0))
        else $error("length or cycles set on non-executed word");
endmodule
